>>> rtl/isc_pkg.sv
// Shared types, widths, register indexes and saturation helpers for the
// inertial sample conditioner. No dependencies; every other rtl file uses it.
package isc_pkg;

   localparam int RAW_WIDTH = 16;

   // accel offset difference, one guard bit above the wider operand plus sign headroom
   localparam int ACC_D_W   = ((RAW_WIDTH > 16) ? RAW_WIDTH : 16) + 2;
   localparam int ACC_P_W   = ACC_D_W + 16;
   localparam int FRESH_W   = ACC_P_W + 17;
   localparam int DECAY_W   = 50;
   localparam int SUM_W     = FRESH_W + 1;
   localparam int GYRO_P_W  = RAW_WIDTH + 17;
   localparam int MAG_P_W   = RAW_WIDTH + 18;

   localparam longint RAW_MAX = (longint'(1) << (RAW_WIDTH - 1)) - 1;
   localparam longint RAW_MIN = -RAW_MAX - 1;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_OFFSETS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSETS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_GAIN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_MOUNT     = 3'd6;

   localparam logic [1:0] MOUNT_SWAP_XY  = 2'd1;
   localparam logic [1:0] MOUNT_SWAP_NEG = 2'd2;

   typedef struct packed {
      logic                        read_ok;
      logic signed [RAW_WIDTH-1:0] raw_ax;
      logic signed [RAW_WIDTH-1:0] raw_ay;
      logic signed [RAW_WIDTH-1:0] raw_az;
      logic signed [RAW_WIDTH-1:0] raw_gx;
      logic signed [RAW_WIDTH-1:0] raw_gy;
      logic signed [RAW_WIDTH-1:0] raw_gz;
      logic signed [RAW_WIDTH-1:0] raw_mx;
      logic signed [RAW_WIDTH-1:0] raw_my;
      logic signed [RAW_WIDTH-1:0] raw_mz;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic signed [31:0] field_x;
      logic signed [31:0] field_y;
      logic signed [31:0] field_z;
   } rsp_data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic capture;
      logic stage1;
      logic stage2;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic read_ok;
      logic rsp_pending;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX)
         r = 32'sh7fffffff;
      else if (v < S32_MIN)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [RAW_WIDTH-1:0] sat_raw(input logic signed [63:0] v);
      logic signed [RAW_WIDTH-1:0] r;
      if (v > RAW_MAX)
         r = RAW_WIDTH'(RAW_MAX);
      else if (v < RAW_MIN)
         r = RAW_WIDTH'(RAW_MIN);
      else
         r = v[RAW_WIDTH-1:0];
      return r;
   endfunction

endpackage

>>> rtl/isc_channels.sv
// Valid/ready channel interfaces: sample request, conditioned response, register write.
// Depends on isc_pkg for payload types and widths.
interface isc_req_if;
   logic                  valid;
   logic                  ready;
   isc_pkg::req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface isc_rsp_if;
   logic                  valid;
   logic                  ready;
   isc_pkg::rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface isc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [isc_pkg::CSR_IDX_W-1:0]    index;
   logic [isc_pkg::CSR_DAT_W-1:0]    wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/imu_sample_conditioner_core.sv
// Inertial sample conditioner: offset, scale and exponential smoothing of one
// accelerometer/gyro/magnetometer triple per transaction on the req_if channel.
// Depends on isc_pkg, isc_channels.sv, isc_ctrl and isc_datapath.
//
// Channels: req_if carries read_ok and nine raw counts; rsp_if returns the nine
// conditioned 32-bit values; csr_if writes one configuration register per
// transaction (index 0..6, other indexes ignored; always ready).
// A request with read_ok low is accepted while idle and produces nothing.
// A good sample is accepted, goes through the two multiply steps and the sum
// step, and its response is valid the cycle after that sum.
// The sequencer steps one sample at a time through the capture, two multiply
// registers and the sum/commit, and accepts a new sample only once back in idle.
// The response sits in an output register; the next sample is accepted while
// it waits, and that sample holds in its sum step until the response is taken.
// Reset (synchronous, active high) restores register defaults and clears the
// smoothing state and the response valid flag.
module imu_sample_conditioner_core (
   input  logic      clock,
   input  logic      reset,
   isc_req_if.sink   req_if,
   isc_rsp_if.source rsp_if,
   isc_csr_if.sink   csr_if
);

   isc_pkg::cmd_type    cmd;
   isc_pkg::status_type status;

   isc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   isc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_if.data),
      .cmd      (cmd),
      .status   (status),
      .rsp      (rsp_if),
      .csr      (csr_if)
   );

endmodule

>>> rtl/isc_ctrl.sv
// Sequencer for the conditioner: accept, two multiply steps, sum and commit.
// Depends on isc_pkg (state, command and status types).
module isc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  isc_pkg::status_type status,
   output isc_pkg::cmd_type    cmd
);

   isc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= isc_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isc_pkg::ST_IDLE: begin
            // a failed read is taken and dropped here
            if (req_valid && status.read_ok)
               state_in = isc_pkg::ST_MUL1;
         end
         isc_pkg::ST_MUL1: state_in = isc_pkg::ST_MUL2;
         isc_pkg::ST_MUL2: state_in = isc_pkg::ST_SUM;
         isc_pkg::ST_SUM: begin
            if (!status.rsp_pending)
               state_in = isc_pkg::ST_IDLE;
         end
         default: state_in = isc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         isc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && status.read_ok;
         end
         isc_pkg::ST_MUL1: cmd.stage1 = 1'b1;
         isc_pkg::ST_MUL2: cmd.stage2 = 1'b1;
         isc_pkg::ST_SUM:  cmd.commit = !status.rsp_pending;
         default: ;
      endcase
   end

endmodule

>>> rtl/isc_datapath.sv
// Datapath: config registers, sample capture, products, smoothing state, output register.
// Depends on isc_pkg and the channel interfaces in isc_channels.sv.
module isc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  isc_pkg::req_data_type req_data,
   input  isc_pkg::cmd_type      cmd,
   output isc_pkg::status_type   status,
   isc_rsp_if.source             rsp,
   isc_csr_if.sink               csr
);

   localparam int RW = isc_pkg::RAW_WIDTH;

   // configuration
   logic [47:0] accel_offsets_ff, gyro_offsets_ff, accel_scales_ff;
   logic [15:0] smooth_weight_ff, gyro_gain_ff, mag_gain_ff;
   logic [1:0]  mag_mount_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_offsets_ff <= '0;
         gyro_offsets_ff  <= '0;
         accel_scales_ff  <= '0;
         smooth_weight_ff <= 16'd65535;
         gyro_gain_ff     <= 16'd17855;
         mag_gain_ff      <= '0;
         mag_mount_ff     <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            isc_pkg::CSR_ACCEL_OFFSETS: accel_offsets_ff <= csr.wdata;
            isc_pkg::CSR_GYRO_OFFSETS:  gyro_offsets_ff  <= csr.wdata;
            isc_pkg::CSR_ACCEL_SCALES:  accel_scales_ff  <= csr.wdata;
            isc_pkg::CSR_SMOOTH_WEIGHT: smooth_weight_ff <= csr.wdata[15:0];
            isc_pkg::CSR_GYRO_GAIN:     gyro_gain_ff     <= csr.wdata[15:0];
            isc_pkg::CSR_MAG_GAIN:      mag_gain_ff      <= csr.wdata[15:0];
            isc_pkg::CSR_MAG_MOUNT:     mag_mount_ff     <= csr.wdata[1:0];
            default: ;
         endcase
      end
   end

   // sample capture
   logic signed [RW-1:0] acc_raw_ff [3];
   logic signed [RW-1:0] gyr_raw_ff [3];
   logic signed [RW-1:0] mag_raw_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_raw_ff[0] <= req_data.raw_ax;
         acc_raw_ff[1] <= req_data.raw_ay;
         acc_raw_ff[2] <= req_data.raw_az;
         gyr_raw_ff[0] <= req_data.raw_gx;
         gyr_raw_ff[1] <= req_data.raw_gy;
         gyr_raw_ff[2] <= req_data.raw_gz;
         mag_raw_ff[0] <= req_data.raw_mx;
         mag_raw_ff[1] <= req_data.raw_my;
         mag_raw_ff[2] <= req_data.raw_mz;
      end
   end

   // first multiply step: offset correction, sign flips, remap, products
   logic signed [isc_pkg::ACC_D_W-1:0]  acc_d   [3];
   logic signed [isc_pkg::ACC_D_W-1:0]  gyr_d   [3];
   logic signed [RW-1:0]                gyr_c   [3];
   logic signed [RW-1:0]                gyr_n   [3];
   logic signed [RW:0]                  mag_m   [3];
   logic signed [isc_pkg::ACC_P_W-1:0]  acc_p_in  [3];
   logic signed [isc_pkg::GYRO_P_W-1:0] gyr_p_in  [3];
   logic signed [isc_pkg::MAG_P_W-1:0]  mag_p_in  [3];
   logic signed [isc_pkg::ACC_P_W-1:0]  acc_p_ff  [3];
   logic signed [isc_pkg::GYRO_P_W-1:0] gyr_p_ff  [3];
   logic signed [isc_pkg::MAG_P_W-1:0]  mag_p_ff  [3];

   always_comb begin
      unique case (mag_mount_ff)
         isc_pkg::MOUNT_SWAP_XY: begin
            mag_m[0] =  (RW+1)'(mag_raw_ff[1]);
            mag_m[1] = -(RW+1)'(mag_raw_ff[0]);
            mag_m[2] = -(RW+1)'(mag_raw_ff[2]);
         end
         isc_pkg::MOUNT_SWAP_NEG: begin
            mag_m[0] = -(RW+1)'(mag_raw_ff[1]);
            mag_m[1] =  (RW+1)'(mag_raw_ff[0]);
            mag_m[2] =  (RW+1)'(mag_raw_ff[2]);
         end
         default: begin
            // unused mount code behaves as the default mount
            mag_m[0] = -(RW+1)'(mag_raw_ff[0]);
            mag_m[1] =  (RW+1)'(mag_raw_ff[1]);
            mag_m[2] = -(RW+1)'(mag_raw_ff[2]);
         end
      endcase

      for (int i = 0; i < 3; i++) begin
         acc_d[i] = isc_pkg::ACC_D_W'(acc_raw_ff[i])
                  - isc_pkg::ACC_D_W'($signed(accel_offsets_ff[16*i +: 16]));
         if (i < 2)
            acc_d[i] = -acc_d[i];
         acc_p_in[i] = acc_d[i] * $signed(accel_scales_ff[16*i +: 16]);

         gyr_d[i] = isc_pkg::ACC_D_W'(gyr_raw_ff[i])
                  - isc_pkg::ACC_D_W'($signed(gyro_offsets_ff[16*i +: 16]));
         gyr_c[i] = isc_pkg::sat_raw(64'(gyr_d[i]));
         if (i != 1)
            gyr_n[i] = isc_pkg::sat_raw(-64'(gyr_c[i]));
         else
            gyr_n[i] = gyr_c[i];
         gyr_p_in[i] = gyr_n[i] * $signed({1'b0, gyro_gain_ff});
         mag_p_in[i] = mag_m[i] * $signed({1'b0, mag_gain_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stage1) begin
         acc_p_ff <= acc_p_in;
         gyr_p_ff <= gyr_p_in;
         mag_p_ff <= mag_p_in;
      end
   end

   // second multiply step: blend weights, saturate gyro and mag
   logic signed [31:0]                 smooth_ff  [3];
   logic signed [31:0]                 smooth_in  [3];
   logic [16:0]                        keep_w;
   logic signed [isc_pkg::DECAY_W-1:0] decay_in   [3];
   logic signed [isc_pkg::FRESH_W-1:0] fresh_in   [3];
   logic signed [isc_pkg::DECAY_W-1:0] decay_ff   [3];
   logic signed [isc_pkg::FRESH_W-1:0] fresh_ff   [3];
   logic signed [31:0]                 rate_in    [3];
   logic signed [31:0]                 field_in   [3];
   logic signed [31:0]                 rate_ff    [3];
   logic signed [31:0]                 field_ff   [3];

   assign keep_w = 17'd65536 - {1'b0, smooth_weight_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         decay_in[i] = smooth_ff[i] * $signed({1'b0, keep_w});
         fresh_in[i] = acc_p_ff[i] * $signed({1'b0, smooth_weight_ff});
         rate_in[i]  = isc_pkg::sat32(64'(gyr_p_ff[i]));
         field_in[i] = isc_pkg::sat32(64'(mag_p_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stage2) begin
         decay_ff <= decay_in;
         fresh_ff <= fresh_in;
         rate_ff  <= rate_in;
         field_ff <= field_in;
      end
   end

   // sum, floor divide by 2^16 (arithmetic shift), saturate
   logic signed [isc_pkg::SUM_W-1:0] blend [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         blend[i]     = isc_pkg::SUM_W'(decay_ff[i]) + isc_pkg::SUM_W'(fresh_ff[i]);
         smooth_in[i] = isc_pkg::sat32(64'(blend[i] >>> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++)
            smooth_ff[i] <= '0;
      end else if (cmd.commit) begin
         smooth_ff <= smooth_in;
      end
   end

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   isc_pkg::rsp_data_type rsp_data_ff;

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff.acc_x   <= smooth_in[0];
         rsp_data_ff.acc_y   <= smooth_in[1];
         rsp_data_ff.acc_z   <= smooth_in[2];
         rsp_data_ff.rate_x  <= rate_ff[0];
         rsp_data_ff.rate_y  <= rate_ff[1];
         rsp_data_ff.rate_z  <= rate_ff[2];
         rsp_data_ff.field_x <= field_ff[0];
         rsp_data_ff.field_y <= field_ff[1];
         rsp_data_ff.field_z <= field_ff[2];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   assign status.read_ok     = req_data.read_ok;
   assign status.rsp_pending = rsp_valid_ff && !rsp.ready;

endmodule

>>> tb/isc_sample_checker.sv
// Watches the request, response and register write channels of the sample conditioner,
// predicts each conditioned sample and compares it field by field. Depends on isc_pkg.
`timescale 1ns / 100ps
module isc_sample_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  isc_pkg::req_data_type         req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  isc_pkg::rsp_data_type         rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [isc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [isc_pkg::CSR_DAT_W-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            samples_in_flight
);

   localparam int RSP_W = $bits(isc_pkg::rsp_data_type);
   localparam logic [15:0] WEIGHT_AT_RESET    = 16'd65535;
   localparam logic [15:0] GYRO_GAIN_AT_RESET = 16'd17855;
   localparam longint RAW_HI = (longint'(1) << (isc_pkg::RAW_WIDTH - 1)) - 1;
   localparam longint RAW_LO = -RAW_HI - 1;
   localparam int PRINT_CAP = 50;

   string field_name [9] = '{"acc_x", "acc_y", "acc_z", "rate_x", "rate_y", "rate_z",
                             "field_x", "field_y", "field_z"};

   // shadow of the block's registers and smoothing state
   logic [47:0] acc_bias, gyr_bias, accel_scl;
   logic [15:0] weight, gyro_gain, mag_gain;
   logic [1:0]  mount;
   longint      smooth_acc [3];

   isc_pkg::rsp_data_type conditioned_q [$];

   initial begin
      mismatch_count = 0;
      samples_in_flight = 0;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic longint lane16(input logic [47:0] word, input int k);
      return longint'($signed(word[16*k +: 16]));
   endfunction

   function automatic longint bound(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [31:0] clip32(input longint v);
      return 32'(bound(v, -64'sd2147483648, 64'sd2147483647));
   endfunction

   // Predicts one good sample and advances the smoothing state.
   function automatic isc_pkg::rsp_data_type condition_sample(input isc_pkg::req_data_type s);
      isc_pkg::rsp_data_type r;
      longint raw_a [3];
      longint raw_g [3];
      longint mx, my, mz, d, p, wt, g;
      longint m [3];
      logic [31:0] v [9];
      raw_a[0] = longint'($signed(s.raw_ax));
      raw_a[1] = longint'($signed(s.raw_ay));
      raw_a[2] = longint'($signed(s.raw_az));
      raw_g[0] = longint'($signed(s.raw_gx));
      raw_g[1] = longint'($signed(s.raw_gy));
      raw_g[2] = longint'($signed(s.raw_gz));
      mx = longint'($signed(s.raw_mx));
      my = longint'($signed(s.raw_my));
      mz = longint'($signed(s.raw_mz));
      wt = longint'(weight);
      for (int k = 0; k < 3; k++) begin
         d = raw_a[k] - lane16(acc_bias, k);
         if (k < 2)
            d = -d;
         p = d * lane16(accel_scl, k);
         // arithmetic shift gives the floor of the weighted sum over 2^16
         smooth_acc[k] = longint'($signed(clip32((smooth_acc[k] * (65536 - wt) + p * wt) >>> 16)));
         v[k] = smooth_acc[k][31:0];
      end
      for (int k = 0; k < 3; k++) begin
         g = bound(raw_g[k] - lane16(gyr_bias, k), RAW_LO, RAW_HI);
         if (k != 1)
            g = bound(-g, RAW_LO, RAW_HI);
         v[3 + k] = clip32(g * longint'(gyro_gain));
      end
      case (mount)
         isc_pkg::MOUNT_SWAP_XY: begin
            m[0] = my;  m[1] = -mx; m[2] = -mz;
         end
         isc_pkg::MOUNT_SWAP_NEG: begin
            m[0] = -my; m[1] = mx;  m[2] = mz;
         end
         default: begin
            m[0] = -mx; m[1] = my;  m[2] = -mz;
         end
      endcase
      for (int k = 0; k < 3; k++)
         v[6 + k] = clip32(m[k] * longint'(mag_gain));
      r.acc_x   = v[0];
      r.acc_y   = v[1];
      r.acc_z   = v[2];
      r.rate_x  = v[3];
      r.rate_y  = v[4];
      r.rate_z  = v[5];
      r.field_x = v[6];
      r.field_y = v[7];
      r.field_z = v[8];
      return r;
   endfunction

   always @(posedge clock) begin
      isc_pkg::rsp_data_type want;
      logic [RSP_W-1:0] got_bits, want_bits;
      if (reset) begin
         acc_bias  = '0;
         gyr_bias  = '0;
         accel_scl = '0;
         weight    = WEIGHT_AT_RESET;
         gyro_gain = GYRO_GAIN_AT_RESET;
         mag_gain  = '0;
         mount     = '0;
         for (int k = 0; k < 3; k++)
            smooth_acc[k] = 0;
         conditioned_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               isc_pkg::CSR_ACCEL_OFFSETS: acc_bias  = csr_wdata;
               isc_pkg::CSR_GYRO_OFFSETS:  gyr_bias  = csr_wdata;
               isc_pkg::CSR_ACCEL_SCALES:  accel_scl = csr_wdata;
               isc_pkg::CSR_SMOOTH_WEIGHT: weight    = csr_wdata[15:0];
               isc_pkg::CSR_GYRO_GAIN:     gyro_gain = csr_wdata[15:0];
               isc_pkg::CSR_MAG_GAIN:      mag_gain  = csr_wdata[15:0];
               isc_pkg::CSR_MAG_MOUNT:     mount     = csr_wdata[1:0];
               default: ;
            endcase
         end
         // a failed read is consumed without a response
         if (req_valid && req_ready && req_data.read_ok)
            conditioned_q.push_back(condition_sample(req_data));
         if (rsp_valid && rsp_ready) begin
            if (conditioned_q.size() == 0) begin
               flag_mismatch("response transaction with no sample outstanding");
            end else begin
               want = conditioned_q.pop_front();
               got_bits = rsp_data;
               want_bits = want;
               for (int k = 0; k < 9; k++)
                  if (got_bits[RSP_W-1-32*k -: 32] !== want_bits[RSP_W-1-32*k -: 32])
                     flag_mismatch($sformatf("%s got %0d expected %0d", field_name[k],
                                             $signed(got_bits[RSP_W-1-32*k -: 32]),
                                             $signed(want_bits[RSP_W-1-32*k -: 32])));
            end
         end
      end
      samples_in_flight <= conditioned_q.size();
   end

endmodule

>>> tb/tb.sv
// Top of the sample conditioner testbench: clock, reset, stimulus and verdict.
// Depends on isc_pkg, the channel interfaces, the core and isc_sample_checker.
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 240;
   localparam logic [1:0] MOUNT_DEFAULT = 2'd0;
   localparam logic [1:0] MOUNT_SPARE   = 2'd3;
   localparam logic [isc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count;
   int   samples_in_flight;
   bit   req_steady;
   bit   rsp_steady;
   int   rsp_stall;
   int   rsp_stall_left;

   isc_req_if req_ch ();
   isc_rsp_if rsp_ch ();
   isc_csr_if csr_ch ();

   imu_sample_conditioner_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   isc_sample_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_data          (req_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_data          (rsp_ch.data),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_wdata         (csr_ch.wdata),
      .mismatch_count    (mismatch_count),
      .samples_in_flight (samples_in_flight)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: after each taken transaction hold ready low for a random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_stall = rsp_steady ? 0 : $urandom_range(0, 5);
         rsp_ch.ready <= (rsp_stall == 0);
         rsp_stall_left <= rsp_stall;
      end else if (rsp_stall_left > 1) begin
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_stall_left <= 0;
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic [15:0] rand_count();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h7fff;
         1: v = 16'h8000;
         2: v = 16'($signed(8'($urandom())));
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic isc_pkg::req_data_type uniform_sample(input logic ok,
                                                           input logic [15:0] v);
      isc_pkg::req_data_type s;
      s = {ok, {9{v}}};
      return s;
   endfunction

   function automatic isc_pkg::req_data_type random_sample();
      isc_pkg::req_data_type s;
      s.read_ok = ($urandom_range(0, 6) != 0);
      s.raw_ax = rand_count();
      s.raw_ay = rand_count();
      s.raw_az = rand_count();
      s.raw_gx = rand_count();
      s.raw_gy = rand_count();
      s.raw_gz = rand_count();
      s.raw_mx = rand_count();
      s.raw_my = rand_count();
      s.raw_mz = rand_count();
      return s;
   endfunction

   // Called and returns at a rising edge; valid stays high into the next call.
   task automatic send_sample(input isc_pkg::req_data_type s);
      int gap;
      bit taken;
      gap = req_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= s;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_csr(input logic [isc_pkg::CSR_IDX_W-1:0] idx, input logic [47:0] v);
      bit taken;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      do begin
         @(negedge clock);
         taken = csr_ch.ready;
         @(posedge clock);
      end while (!taken);
      csr_ch.valid <= 1'b0;
      repeat (1 + $urandom_range(0, 5)) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (samples_in_flight != 0);
      // a dropped sample leaves nothing to wait for, so allow the pipeline to empty
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_all(input logic [47:0] aoff, input logic [47:0] goff,
                              input logic [47:0] scl, input logic [47:0] wt,
                              input logic [47:0] ggain, input logic [47:0] mgain,
                              input logic [47:0] mnt);
      write_csr(isc_pkg::CSR_ACCEL_OFFSETS, aoff);
      write_csr(isc_pkg::CSR_GYRO_OFFSETS, goff);
      write_csr(isc_pkg::CSR_ACCEL_SCALES, scl);
      write_csr(isc_pkg::CSR_SMOOTH_WEIGHT, wt);
      write_csr(isc_pkg::CSR_GYRO_GAIN, ggain);
      write_csr(isc_pkg::CSR_MAG_GAIN, mgain);
      write_csr(isc_pkg::CSR_MAG_MOUNT, mnt);
      if ($urandom_range(0, 1))
         write_csr(CSR_UNUSED, rand48());
   endtask

   initial begin
      cycle_count = 0;
      reset = 1'b1;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults after reset
      send_sample(uniform_sample(1'b1, 16'h0000));
      send_sample(uniform_sample(1'b1, 16'h7fff));
      send_sample(uniform_sample(1'b1, 16'h8000));
      send_sample(uniform_sample(1'b0, 16'h7fff));
      wait_drained();

      // extreme offsets and scales drive the saturating paths
      program_all({3{16'h8000}}, {16'h7fff, 16'h8000, 16'h7fff},
                  {16'h7fff, 16'h8000, 16'h7fff}, 48'hffff, 48'hffff, 48'hffff,
                  48'(MOUNT_DEFAULT));
      send_sample(uniform_sample(1'b1, 16'h7fff));
      send_sample(uniform_sample(1'b1, 16'h8000));
      send_sample(random_sample());
      send_sample(uniform_sample(1'b0, 16'h1234));
      wait_drained();
      write_csr(isc_pkg::CSR_MAG_MOUNT, 48'(isc_pkg::MOUNT_SWAP_XY));
      send_sample(uniform_sample(1'b1, 16'h8000));
      wait_drained();
      write_csr(isc_pkg::CSR_MAG_MOUNT, 48'(isc_pkg::MOUNT_SWAP_NEG));
      send_sample(uniform_sample(1'b1, 16'h8000));
      wait_drained();
      write_csr(isc_pkg::CSR_MAG_MOUNT, 48'(MOUNT_SPARE));
      send_sample(uniform_sample(1'b1, 16'h8000));
      wait_drained();
      // zero weight freezes the smoothed value
      write_csr(isc_pkg::CSR_SMOOTH_WEIGHT, 48'h0);
      send_sample(uniform_sample(1'b1, 16'h0000));
      send_sample(random_sample());
      wait_drained();
      write_csr(isc_pkg::CSR_SMOOTH_WEIGHT, 48'h1);
      send_sample(uniform_sample(1'b1, 16'h7fff));
      wait_drained();
      write_csr(CSR_UNUSED, {48{1'b1}});
      send_sample(uniform_sample(1'b1, 16'h0001));

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: program_all({3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}, 48'hffff,
                           48'hffff, 48'hffff, 48'(MOUNT_DEFAULT));
            1: program_all({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}, 48'h0,
                           48'h0, 48'h0, 48'(isc_pkg::MOUNT_SWAP_XY));
            2: program_all(rand48(), rand48(), {3{16'h1000}}, 48'h1, rand48(), rand48(),
                           48'(isc_pkg::MOUNT_SWAP_NEG));
            3: program_all(rand48(), rand48(), rand48(), 48'h8000, rand48(), rand48(),
                           48'(MOUNT_SPARE));
            default: program_all(rand48(), rand48(), rand48(), rand48(), rand48(),
                                 rand48(), rand48());
         endcase
         req_steady = (phase == 5) || ($urandom_range(0, 4) == 0);
         rsp_steady <= (phase == 5) || ($urandom_range(0, 4) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(random_sample());
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
